FILE: src/gesture_pointer_event_engine_defines.svh
// Assertion macros shared by the gesture pointer event engine RTL.
`ifndef GESTURE_POINTER_EVENT_ENGINE_DEFINES_SVH
`define GESTURE_POINTER_EVENT_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GPE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gesture pointer engine check failed (same cycle)");

// Next-cycle implication, checked on every rising edge outside reset.
`define GPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gesture pointer engine check failed (next cycle)");

`endif

FILE: src/gpe_pkg.sv
// Shared types, register map and helper functions of the gesture pointer event engine.
package gpe_pkg;

    // Field widths.
    localparam int COORD_W  = 11;
    localparam int SCREEN_W = 12;
    localparam int PROD_W   = COORD_W + SCREEN_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // The quotient is always below the screen size, so it fits in twelve bits.
    localparam int DIV_STEPS = SCREEN_W;
    localparam int CNT_W     = 4;

    // Dwell counter saturation value.
    localparam logic [5:0] DWELL_MAX = 6'd63;

    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic [SCREEN_W-1:0] t_screen;
    typedef logic [PROD_W-1:0]   t_prod;
    typedef logic [ACC_W-1:0]    t_acc;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_ENABLE_MASK   = 3'd0;
    localparam logic [2:0] REG_SMOOTH_RADIUS = 3'd1;
    localparam logic [2:0] REG_PINCH_RADIUS  = 3'd2;
    localparam logic [2:0] REG_DWELL_FRAMES  = 3'd3;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;
    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd6;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd7;

    // Bits of the enable mask.
    localparam int EN_EMULATION = 0;
    localparam int EN_SCROLL    = 1;
    localparam int EN_LEFT      = 2;
    localparam int EN_RIGHT     = 3;

    // Absolute difference of two coordinates.
    function automatic t_coord abs_diff(input t_coord a, input t_coord b);
        t_coord r;
        if (a >= b) begin
            r = a - b;
        end else begin
            r = b - a;
        end
        return r;
    endfunction

endpackage

FILE: src/gesture_pointer_event_engine.sv
// Gesture pointer event engine: converts per-frame marker centroids into pointer events.
// An accepted transaction goes straight to the output state when emulation is off or the
// index marker is absent. Otherwise the sequencer squares the index distance to the anchor,
// tests the anchor against the margin box and, inside it, maps the anchor to the screen with
// two 12-step restoring divisions (one per axis); with the thumb present it then squares the
// pinch distance. A stalled output holds the sequencer in its output state until the result
// can be handed on. All squares and the screen scaling share one 11 by 12 bit multiplier
// stepped by a small sequencer, and the divider reuses one subtractor. The input stall is
// low only while the sequencer is idle; a finished result waits in the output register, so
// the next transaction is taken while it is still pending. Configuration is written through
// the APB-style port at byte address four times the register index.
`include "gesture_pointer_event_engine_defines.svh"

module gesture_pointer_event_engine #(
    parameter int MARGIN = 100
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gpe_pkg::ADDR_W-1:0]    paddr,
    input  logic [gpe_pkg::DATA_W-1:0]    pwdata,
    output logic [gpe_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,

    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [10:0]                   i_index_x,
    input  logic [10:0]                   i_index_y,
    input  logic [10:0]                   i_thumb_x,
    input  logic [10:0]                   i_thumb_y,

    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_moved,
    output logic [11:0]                   o_pointer_x,
    output logic [11:0]                   o_pointer_y,
    output logic                          o_right_click,
    output logic                          o_scroll_up,
    output logic                          o_scroll_down,
    output logic                          o_left_press,
    output logic                          o_left_release
);

    // Margin constants in the width of the box arithmetic.
    localparam logic [gpe_pkg::SCREEN_W-1:0] MARGIN_V  = gpe_pkg::SCREEN_W'(MARGIN);
    localparam logic [gpe_pkg::SCREEN_W-1:0] MARGIN_V2 = gpe_pkg::SCREEN_W'(2 * MARGIN);

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_D2A  = 4'd1;
    localparam logic [3:0] ST_D2B  = 4'd2;
    localparam logic [3:0] ST_BOX  = 4'd3;
    localparam logic [3:0] ST_NUMX = 4'd4;
    localparam logic [3:0] ST_DIVX = 4'd5;
    localparam logic [3:0] ST_NUMY = 4'd6;
    localparam logic [3:0] ST_DIVY = 4'd7;
    localparam logic [3:0] ST_P2A  = 4'd8;
    localparam logic [3:0] ST_P2B  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    localparam logic [gpe_pkg::CNT_W-1:0] LAST_STEP = gpe_pkg::CNT_W'(gpe_pkg::DIV_STEPS - 1);

    // Configuration registers.
    logic [3:0]             r_enable_mask;
    logic [3:0]             r_smooth_radius;
    logic [6:0]             r_pinch_radius;
    logic [4:0]             r_dwell_frames;
    gpe_pkg::t_screen       r_screen_width;
    gpe_pkg::t_screen       r_screen_height;
    gpe_pkg::t_coord        r_frame_width;
    gpe_pkg::t_coord        r_frame_height;

    // Tracking state.
    gpe_pkg::t_coord        r_anchor_x;
    gpe_pkg::t_coord        r_anchor_y;
    gpe_pkg::t_screen       r_cursor_x;
    gpe_pkg::t_screen       r_cursor_y;
    gpe_pkg::t_screen       r_last_x;
    gpe_pkg::t_screen       r_last_y;
    logic [5:0]             r_dwell_counter;
    logic                   r_pinch_flag;
    logic                   r_up_flag;
    logic                   r_down_flag;
    logic                   r_press_armed;
    logic                   r_release_armed;

    // Sequencer and working registers.
    logic [3:0]             r_state;
    gpe_pkg::t_coord        r_ix;
    gpe_pkg::t_coord        r_iy;
    gpe_pkg::t_coord        r_tx;
    gpe_pkg::t_coord        r_ty;
    logic                   r_thumb_ok;
    gpe_pkg::t_acc          r_acc;
    gpe_pkg::t_coord        r_rem;
    gpe_pkg::t_screen       r_q;
    gpe_pkg::t_screen       r_qx;
    logic [gpe_pkg::CNT_W-1:0] r_cnt;

    // Pending result flags of the transaction at work.
    logic                   r_res_moved;
    logic                   r_res_rclick;
    logic                   r_res_sup;
    logic                   r_res_sdn;
    logic                   r_res_lpress;
    logic                   r_res_lrel;

    logic                   in_accept;
    logic                   cfg_write;
    logic                   active;
    logic                   out_free;

    // Shared multiplier.
    gpe_pkg::t_coord        mul_a;
    gpe_pkg::t_screen       mul_b;
    gpe_pkg::t_prod         mul_p;
    gpe_pkg::t_acc          sum_sq;

    // Box test and divider.
    logic                   box_x;
    logic                   box_y;
    gpe_pkg::t_screen       den_x_full;
    gpe_pkg::t_screen       den_y_full;
    gpe_pkg::t_coord        div_den;
    gpe_pkg::t_screen       div_trial;
    logic                   div_take;
    gpe_pkg::t_coord        div_rem_next;

    // Flag evaluation for the thumb stage.
    logic                   same_pos;
    logic [5:0]             dwell_inc;
    logic                   rclick;
    logic                   pinch_new;
    logic                   up_new;
    logic                   down_new;

    assign in_accept = i_in_valid && !o_in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign o_in_stall = (r_state != ST_IDLE);
    assign pready = 1'b1;
    assign out_free = !o_out_valid || !i_out_stall;
    assign active = r_enable_mask[gpe_pkg::EN_EMULATION] && ((i_index_x | i_index_y) != '0);

    // Configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask   <= 4'd14;
            r_smooth_radius <= 4'd8;
            r_pinch_radius  <= 7'd66;
            r_dwell_frames  <= 5'd20;
            r_screen_width  <= 12'd1920;
            r_screen_height <= 12'd1080;
            r_frame_width   <= 11'd640;
            r_frame_height  <= 11'd480;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                gpe_pkg::REG_ENABLE_MASK:   r_enable_mask   <= pwdata[3:0];
                gpe_pkg::REG_SMOOTH_RADIUS: r_smooth_radius <= pwdata[3:0];
                gpe_pkg::REG_PINCH_RADIUS:  r_pinch_radius  <= pwdata[6:0];
                gpe_pkg::REG_DWELL_FRAMES:  r_dwell_frames  <= pwdata[4:0];
                gpe_pkg::REG_SCREEN_WIDTH:  r_screen_width  <= pwdata[11:0];
                gpe_pkg::REG_SCREEN_HEIGHT: r_screen_height <= pwdata[11:0];
                gpe_pkg::REG_FRAME_WIDTH:   r_frame_width   <= pwdata[10:0];
                gpe_pkg::REG_FRAME_HEIGHT:  r_frame_height  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Configuration read.
    always_comb begin
        unique case (paddr[4:2])
            gpe_pkg::REG_ENABLE_MASK:   prdata = {28'd0, r_enable_mask};
            gpe_pkg::REG_SMOOTH_RADIUS: prdata = {28'd0, r_smooth_radius};
            gpe_pkg::REG_PINCH_RADIUS:  prdata = {25'd0, r_pinch_radius};
            gpe_pkg::REG_DWELL_FRAMES:  prdata = {27'd0, r_dwell_frames};
            gpe_pkg::REG_SCREEN_WIDTH:  prdata = {20'd0, r_screen_width};
            gpe_pkg::REG_SCREEN_HEIGHT: prdata = {20'd0, r_screen_height};
            gpe_pkg::REG_FRAME_WIDTH:   prdata = {21'd0, r_frame_width};
            gpe_pkg::REG_FRAME_HEIGHT:  prdata = {21'd0, r_frame_height};
            default:                    prdata = '0;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_D2A: begin
                mul_a = gpe_pkg::abs_diff(r_anchor_x, r_ix);
                mul_b = {1'b0, mul_a};
            end
            ST_D2B: begin
                mul_a = gpe_pkg::abs_diff(r_anchor_y, r_iy);
                mul_b = {1'b0, mul_a};
            end
            ST_NUMX: begin
                mul_a = 11'({1'b0, r_anchor_x} - MARGIN_V);
                mul_b = r_screen_width;
            end
            ST_NUMY: begin
                mul_a = 11'({1'b0, r_anchor_y} - MARGIN_V);
                mul_b = r_screen_height;
            end
            ST_P2A: begin
                mul_a = gpe_pkg::abs_diff(r_tx, r_ix);
                mul_b = {1'b0, mul_a};
            end
            ST_P2B: begin
                mul_a = gpe_pkg::abs_diff(r_ty, r_iy);
                mul_b = {1'b0, mul_a};
            end
            default: ;
        endcase
    end

    assign mul_p  = gpe_pkg::t_prod'(mul_a) * gpe_pkg::t_prod'(mul_b);
    assign sum_sq = r_acc + {1'b0, mul_p};

    // Margin box test on the current anchor.
    assign box_x = ({1'b0, r_anchor_x} > MARGIN_V) &&
                   (({1'b0, r_anchor_x} + MARGIN_V) < {1'b0, r_frame_width});
    assign box_y = ({1'b0, r_anchor_y} > MARGIN_V) &&
                   (({1'b0, r_anchor_y} + MARGIN_V) < {1'b0, r_frame_height});
    assign den_x_full = {1'b0, r_frame_width} - MARGIN_V2;
    assign den_y_full = {1'b0, r_frame_height} - MARGIN_V2;

    // One restoring division step.
    assign div_den      = (r_state == ST_DIVY) ? den_y_full[10:0] : den_x_full[10:0];
    assign div_trial    = {r_rem, r_q[gpe_pkg::SCREEN_W-1]};
    assign div_take     = div_trial >= {1'b0, div_den};
    assign div_rem_next = div_take ? 11'(div_trial - {1'b0, div_den}) : div_trial[10:0];

    // Dwell, pinch, scroll and click decisions for the thumb stage.
    assign same_pos  = (r_last_x == r_cursor_x) && (r_last_y == r_cursor_y);
    assign dwell_inc = same_pos ?
                       ((r_dwell_counter < gpe_pkg::DWELL_MAX) ? r_dwell_counter + 6'd1
                                                               : r_dwell_counter)
                       : 6'd0;
    assign rclick    = r_enable_mask[gpe_pkg::EN_RIGHT] &&
                       (dwell_inc == {1'b0, r_dwell_frames}) &&
                       !r_up_flag && !r_down_flag && !r_pinch_flag;
    assign pinch_new = sum_sq < (gpe_pkg::t_acc'(r_pinch_radius) *
                                 gpe_pkg::t_acc'(r_pinch_radius));
    assign up_new    = (r_tx > r_anchor_x) && (r_ty < r_anchor_y) && !pinch_new;
    assign down_new  = (r_tx > r_anchor_x) && (r_ty > r_anchor_y) && !pinch_new;

    // Sequencer and tracking state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_anchor_x      <= '0;
            r_anchor_y      <= '0;
            r_cursor_x      <= '0;
            r_cursor_y      <= '0;
            r_last_x        <= '0;
            r_last_y        <= '0;
            r_dwell_counter <= '0;
            r_pinch_flag    <= 1'b0;
            r_up_flag       <= 1'b0;
            r_down_flag     <= 1'b0;
            r_press_armed   <= 1'b1;
            r_release_armed <= 1'b1;
            r_cnt           <= '0;
            r_res_moved     <= 1'b0;
            r_res_rclick    <= 1'b0;
            r_res_sup       <= 1'b0;
            r_res_sdn       <= 1'b0;
            r_res_lpress    <= 1'b0;
            r_res_lrel      <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_res_moved  <= active;
                        r_res_rclick <= 1'b0;
                        r_res_sup    <= 1'b0;
                        r_res_sdn    <= 1'b0;
                        r_res_lpress <= 1'b0;
                        r_res_lrel   <= 1'b0;
                        r_state      <= active ? ST_D2A : ST_OUT;
                    end
                end
                ST_D2A: begin
                    r_state <= ST_D2B;
                end
                ST_D2B: begin
                    // Anchor follows the index once it leaves the dead zone.
                    if (sum_sq >= (gpe_pkg::t_acc'(r_smooth_radius) *
                                   gpe_pkg::t_acc'(r_smooth_radius))) begin
                        r_anchor_x <= r_ix;
                        r_anchor_y <= r_iy;
                    end
                    r_state <= ST_BOX;
                end
                ST_BOX: begin
                    if (box_x && box_y) begin
                        r_state <= ST_NUMX;
                    end else begin
                        r_state <= r_thumb_ok ? ST_P2A : ST_OUT;
                    end
                end
                ST_NUMX: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIVX;
                end
                ST_DIVX: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= ST_NUMY;
                    end
                end
                ST_NUMY: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIVY;
                end
                ST_DIVY: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_cursor_x <= r_qx;
                        r_cursor_y <= {r_q[gpe_pkg::SCREEN_W-2:0], div_take};
                        r_state    <= r_thumb_ok ? ST_P2A : ST_OUT;
                    end
                end
                ST_P2A: begin
                    r_state <= ST_P2B;
                end
                ST_P2B: begin
                    r_dwell_counter <= rclick ? 6'd0 : dwell_inc;
                    r_res_rclick    <= rclick;
                    r_last_x        <= r_cursor_x;
                    r_last_y        <= r_cursor_y;
                    r_pinch_flag    <= pinch_new;
                    if (r_enable_mask[gpe_pkg::EN_SCROLL]) begin
                        r_up_flag   <= up_new;
                        r_down_flag <= down_new;
                        r_res_sup   <= up_new;
                        r_res_sdn   <= down_new;
                    end
                    if (r_enable_mask[gpe_pkg::EN_LEFT]) begin
                        if (pinch_new) begin
                            if (r_press_armed) begin
                                r_res_lpress    <= 1'b1;
                                r_press_armed   <= 1'b0;
                                r_release_armed <= 1'b1;
                            end
                        end else if (r_release_armed) begin
                            r_res_lrel      <= 1'b1;
                            r_release_armed <= 1'b0;
                        end else begin
                            r_press_armed <= 1'b1;
                        end
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Working datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ix       <= i_index_x;
            r_iy       <= i_index_y;
            r_tx       <= i_thumb_x;
            r_ty       <= i_thumb_y;
            r_thumb_ok <= (i_thumb_x | i_thumb_y) != '0;
        end
        case (r_state) inside
            ST_D2A, ST_P2A: begin
                r_acc <= {1'b0, mul_p};
            end
            ST_NUMX, ST_NUMY: begin
                // The quotient stays below 2^12, so the top bits start as the remainder.
                r_rem <= mul_p[gpe_pkg::PROD_W-1:gpe_pkg::SCREEN_W];
                r_q   <= mul_p[gpe_pkg::SCREEN_W-1:0];
            end
            ST_DIVX, ST_DIVY: begin
                r_rem <= div_rem_next;
                r_q   <= {r_q[gpe_pkg::SCREEN_W-2:0], div_take};
                if (r_state == ST_DIVX && r_cnt == LAST_STEP) begin
                    r_qx <= {r_q[gpe_pkg::SCREEN_W-2:0], div_take};
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            o_moved        <= r_res_moved;
            o_pointer_x    <= r_cursor_x;
            o_pointer_y    <= r_cursor_y;
            o_right_click  <= r_res_rclick;
            o_scroll_up    <= r_res_sup;
            o_scroll_down  <= r_res_sdn;
            o_left_press   <= r_res_lpress;
            o_left_release <= r_res_lrel;
        end
    end

    // Checks.
    `GPE_ASSERT_NEXT(a_inactive_skips, i_clk, i_rst_n, in_accept && !active, r_state == ST_OUT)
    `GPE_ASSERT_NEXT(a_out_loads, i_clk, i_rst_n, r_state == ST_OUT && out_free, o_out_valid && r_state == ST_IDLE)
    `GPE_ASSERT_SAME(a_idle_flags, i_clk, i_rst_n, o_out_valid && !o_moved, !o_right_click && !o_scroll_up && !o_scroll_down && !o_left_press && !o_left_release)
    `GPE_ASSERT_SAME(a_left_excl, i_clk, i_rst_n, o_out_valid, !(o_left_press && o_left_release) && !(o_scroll_up && o_scroll_down))

endmodule
